@@ sv/stack_arithmetic_unit_assert.svh @@
// Assertion macros for the stack arithmetic unit.
`ifndef STACK_ARITHMETIC_UNIT_ASSERT_SVH
`define STACK_ARITHMETIC_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/sau_pkg.sv @@
// Shared constants for the stack arithmetic unit.
package sau_pkg;

  localparam int CELL_W          = 64;
  localparam int DEPTH_W         = 8;
  localparam int KIND_W          = 3;
  localparam int IN_TDATA_W      = 64;
  localparam int OUT_TDATA_W     = 80;
  localparam int STACK_DEPTH_DEF = 256;

  localparam logic [KIND_W-1:0] KIND_PUSH     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SUB      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MUL      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DIV      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_POP_NUM  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_POP_CHAR = 3'd6;

endpackage

@@ sv/sau_mem.sv @@
// Stack cell memory: one write port, two registered read ports.
module sau_mem #(
  parameter int STACK_DEPTH = sau_pkg::STACK_DEPTH_DEF,
  parameter int AW          = $clog2(STACK_DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             waddr,
  input  logic [sau_pkg::CELL_W-1:0] wdata,
  input  logic                      rd_en,
  input  logic [AW-1:0]             raddr_a,
  input  logic [AW-1:0]             raddr_b,
  output logic [sau_pkg::CELL_W-1:0] rdata_a,
  output logic [sau_pkg::CELL_W-1:0] rdata_b
);
  import sau_pkg::*;

  logic [CELL_W-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ sv/sau_mul.sv @@
// 64-bit wrapping multiplier built from three 32x32 partial products.
module sau_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sau_pkg::CELL_W-1:0] op_a,
  input  logic [sau_pkg::CELL_W-1:0] op_b,
  output logic                       done,
  output logic [sau_pkg::CELL_W-1:0] product
);
  import sau_pkg::*;

  localparam int HALF_W = CELL_W / 2;

  localparam logic [1:0] PH_LL = 2'd0;
  localparam logic [1:0] PH_LH = 2'd1;
  localparam logic [1:0] PH_HL = 2'd2;
  localparam logic [1:0] PH_END = 2'd3;

  logic              busy_r;
  logic              done_r;
  logic [1:0]        phase_r;
  logic [CELL_W-1:0] a_r;
  logic [CELL_W-1:0] b_r;
  logic [CELL_W-1:0] prod_r;
  logic [CELL_W-1:0] acc_r;
  logic [HALF_W-1:0] mx;
  logic [HALF_W-1:0] my;

  always_comb begin
    mx = (phase_r == PH_HL) ? a_r[CELL_W-1:HALF_W] : a_r[HALF_W-1:0];
    my = (phase_r == PH_LH) ? b_r[CELL_W-1:HALF_W] : b_r[HALF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= PH_LL;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= PH_LL;
      end else if (busy_r) begin
        phase_r <= phase_r + 2'd1;
        if (phase_r == PH_END) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= op_a;
      b_r <= op_b;
    end else if (busy_r) begin
      if (phase_r != PH_END) begin
        prod_r <= CELL_W'(mx) * CELL_W'(my);
      end
      case (phase_r) inside
        PH_LH:   acc_r <= prod_r;
        PH_HL,
        PH_END:  acc_r[CELL_W-1:HALF_W] <= acc_r[CELL_W-1:HALF_W] + prod_r[HALF_W-1:0];
        default: acc_r <= acc_r;
      endcase
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

@@ sv/sau_div.sv @@
// Signed 64-bit divider, one quotient bit per cycle, truncating toward zero.
module sau_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sau_pkg::CELL_W-1:0] dividend,
  input  logic [sau_pkg::CELL_W-1:0] divisor,
  output logic                       done,
  output logic [sau_pkg::CELL_W-1:0] quotient
);
  import sau_pkg::*;

  localparam int CNT_W = $clog2(CELL_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CELL_W - 1);

  logic              busy_r;
  logic              fix_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              neg_r;
  logic [CELL_W-1:0] mb_r;
  logic [CELL_W-1:0] rem_r;
  logic [CELL_W-1:0] quo_r;
  logic [CELL_W-1:0] q_r;
  logic [CELL_W:0]   rem_sh;
  logic [CELL_W:0]   diff;

  always_comb begin
    rem_sh = {rem_r, quo_r[CELL_W-1]};
    diff   = rem_sh - {1'b0, mb_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      fix_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          fix_r  <= 1'b1;
        end
      end else if (fix_r) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[CELL_W-1] ^ divisor[CELL_W-1];
      mb_r  <= divisor[CELL_W-1] ? (CELL_W'(0) - divisor) : divisor;
      quo_r <= dividend[CELL_W-1] ? (CELL_W'(0) - dividend) : dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      if (!diff[CELL_W]) begin
        rem_r <= diff[CELL_W-1:0];
        quo_r <= {quo_r[CELL_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[CELL_W-1:0];
        quo_r <= {quo_r[CELL_W-2:0], 1'b0};
      end
    end else if (fix_r) begin
      q_r <= neg_r ? (CELL_W'(0) - quo_r) : quo_r;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

@@ sv/stack_arithmetic_unit.sv @@
// Stack arithmetic unit top level: control, operand selection and result word.
//
// One operation word is taken at a time. The two top cells are read from the
// stack memory when the word is accepted; the result of a push or of an
// arithmetic operation is written back once the output register is free, and
// the pops write nothing back. Multiply works through the three 32x32 partial
// products of the multiplier, and a divide with a nonzero divisor through the
// one-bit-per-cycle divider. A result word waits in the output register while
// the next operation word is accepted and read; it is written back once the
// output register is free.
`include "stack_arithmetic_unit_assert.svh"

module stack_arithmetic_unit #(
  parameter int STACK_DEPTH = sau_pkg::STACK_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sau_pkg::IN_TDATA_W-1:0]  in_tdata,  // [63:0] literal
  input  logic [sau_pkg::KIND_W-1:0]      in_tuser,  // [2:0] kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sau_pkg::OUT_TDATA_W-1:0] out_tdata, // [63:0] popped_value, [71:64] depth,
                                                     // [72] underflow, [73] overflow,
                                                     // [74] divide_by_zero, [79:75] zero
  output logic                            out_tuser  // [0] has_value
);
  import sau_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam logic [AW-1:0] DEPTH_MAX = AW'(STACK_DEPTH - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]             state_r;
  logic [1:0]             state_nxt;
  logic [AW-1:0]          depth_r;
  logic [AW-1:0]          depth_nxt;
  logic [KIND_W-1:0]      kind_r;
  logic [CELL_W-1:0]      lit_r;
  logic [CELL_W-1:0]      res_r;
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_tuser_r;

  logic                   accept;
  logic                   out_free;
  logic                   fin_go;
  logic                   is_long;
  logic                   mul_start;
  logic                   div_start;
  logic                   mul_done;
  logic                   div_done;
  logic [CELL_W-1:0]      mul_p;
  logic [CELL_W-1:0]      div_q;
  logic [CELL_W-1:0]      rdata_a;
  logic [CELL_W-1:0]      rdata_b;
  logic [CELL_W-1:0]      op_a;
  logic [CELL_W-1:0]      op_b;
  logic [CELL_W-1:0]      res_val;
  logic [AW-1:0]          pop_depth;

  logic                   wr_en;
  logic [AW-1:0]          waddr;
  logic [CELL_W-1:0]      wdata;
  logic                   has_val;
  logic [CELL_W-1:0]      val;
  logic                   under;
  logic                   over;
  logic                   dz;

  sau_mem #(
    .STACK_DEPTH (STACK_DEPTH),
    .AW          (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .waddr   (waddr),
    .wdata   (wdata),
    .rd_en   (accept),
    .raddr_a (depth_r - AW'(2)),
    .raddr_b (depth_r - AW'(1)),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  sau_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (op_a),
    .op_b    (op_b),
    .done    (mul_done),
    .product (mul_p)
  );

  sau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (op_a),
    .divisor  (op_b),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    op_b      = (depth_r != '0) ? rdata_b : '0;
    op_a      = (depth_r >= AW'(2)) ? rdata_a : '0;
    pop_depth = (depth_r >= AW'(2)) ? (depth_r - AW'(2)) : '0;
    is_long   = (kind_r == KIND_MUL) || ((kind_r == KIND_DIV) && (op_b != '0));
    mul_start = (state_r == ST_EXEC) && (kind_r == KIND_MUL);
    div_start = (state_r == ST_EXEC) && (kind_r == KIND_DIV) && (op_b != '0);
    fin_go    = out_free && (((state_r == ST_EXEC) && !is_long) || (state_r == ST_DONE));
  end

  always_comb begin
    if (state_r == ST_DONE) begin
      res_val = res_r;
    end else if (kind_r == KIND_ADD) begin
      res_val = op_a + op_b;
    end else if (kind_r == KIND_SUB) begin
      res_val = op_a - op_b;
    end else begin
      res_val = '0;
    end
  end

  always_comb begin
    wr_en     = 1'b0;
    waddr     = depth_r;
    wdata     = res_val;
    depth_nxt = depth_r;
    has_val   = 1'b0;
    val       = '0;
    under     = 1'b0;
    over      = 1'b0;
    dz        = 1'b0;
    unique case (kind_r) inside
      KIND_PUSH: begin
        wdata = lit_r;
        if (depth_r >= DEPTH_MAX) begin
          over = 1'b1;
        end else begin
          wr_en     = fin_go;
          depth_nxt = depth_r + AW'(1);
        end
      end
      KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
        under     = (depth_r < AW'(2));
        dz        = (kind_r == KIND_DIV) && (op_b == '0);
        wr_en     = fin_go;
        waddr     = pop_depth;
        depth_nxt = pop_depth + AW'(1);
      end
      KIND_POP_NUM, KIND_POP_CHAR: begin
        has_val   = 1'b1;
        under     = (depth_r == '0);
        depth_nxt = under ? '0 : (depth_r - AW'(1));
        val       = (kind_r == KIND_POP_CHAR) ? {{(CELL_W-8){1'b0}}, op_b[7:0]} : op_b;
      end
      default: begin
        depth_nxt = depth_r;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (is_long) begin
          state_nxt = ST_WAIT;
        end else if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WAIT: if (mul_done || div_done) state_nxt = ST_DONE;
      ST_DONE: if (fin_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      depth_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin_go) begin
        depth_r      <= depth_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_tuser;
      lit_r  <= in_tdata[CELL_W-1:0];
    end
    if ((state_r == ST_WAIT) && (mul_done || div_done)) begin
      res_r <= (kind_r == KIND_MUL) ? mul_p : div_q;
    end
    if (fin_go) begin
      out_tdata_r <= {5'b0, dz, over, under, DEPTH_W'(depth_nxt), val};
      out_tuser_r <= has_val;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `SAU_ASSERT(a_depth_bound, depth_r <= DEPTH_MAX, "stack depth beyond capacity")
  `SAU_ASSERT(a_unit_done_wait, (mul_done || div_done) |-> (state_r == ST_WAIT),
              "arithmetic unit finished outside wait state")
  `SAU_ASSERT(a_full_push_hold, (fin_go && (kind_r == KIND_PUSH) && (depth_r >= DEPTH_MAX))
              |=> (depth_r == $past(depth_r)), "dropped push changed the depth")

endmodule
